### src/affinv_pkg.sv
// shared sizes, types and pipeline records for the affine matrix inverse unit
`default_nettype none

package affinv_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LIMIT_W    = 32;
    localparam int LANES      = 6;
    localparam int PROD_W     = 2 * COEF_WIDTH;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int QBITS      = COEF_WIDTH + 2;
    localparam int RW         = 2 * COEF_WIDTH + QBITS + FRAC_BITS + 2;
    localparam int USER_W     = 2;

    // lane order on the data bus and inside the pipeline
    localparam int L_A00 = 0;
    localparam int L_A01 = 1;
    localparam int L_A10 = 2;
    localparam int L_A11 = 3;
    localparam int L_SX  = 4;
    localparam int L_SY  = 5;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    // sideband that rides along with every request
    typedef struct packed {
        logic                             valid;
        logic                             sing;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0][COEF_WIDTH-1:0] coef;
    } t_tag;

    // state handed from one divider cell to the next
    typedef struct packed {
        t_tag                        tag;
        logic [RW-1:0]               ds;
        logic [LANES-1:0][RW-1:0]    rem;
        logic [LANES-1:0][QBITS-1:0] quo;
    } t_div;

endpackage

`default_nettype wire

### src/affinv_front.sv
// products, determinant, numerators and divider setup (three stages)
`default_nettype none

module affinv_front
    import affinv_pkg::*;
(
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire [LANES-1:0][COEF_WIDTH-1:0]  i_coef,
    input  wire [LIMIT_W-1:0]                i_limit,
    output t_div                             o_div
);

    logic                             r1_valid;
    logic [LANES-1:0][COEF_WIDTH-1:0] r1_coef;
    logic signed [PROD_W-1:0]         r1_prod [LANES];
    logic signed [PROD_W-1:0]         n1_prod [LANES];

    logic                             r2_valid;
    logic [LANES-1:0][COEF_WIDTH-1:0] r2_coef;
    logic signed [DIFF_W-1:0]         r2_det;
    logic signed [DIFF_W-1:0]         r2_tx;
    logic signed [DIFF_W-1:0]         r2_ty;

    t_div r_div;
    t_div n_div;

    t_coef c00, c01, c10, c11, csx, csy;

    assign c00 = t_coef'(i_coef[L_A00]);
    assign c01 = t_coef'(i_coef[L_A01]);
    assign c10 = t_coef'(i_coef[L_A10]);
    assign c11 = t_coef'(i_coef[L_A11]);
    assign csx = t_coef'(i_coef[L_SX]);
    assign csy = t_coef'(i_coef[L_SY]);

    // six exact products
    always_comb begin
        n1_prod[0] = PROD_W'(c00) * PROD_W'(c11);
        n1_prod[1] = PROD_W'(c01) * PROD_W'(c10);
        n1_prod[2] = PROD_W'(c10) * PROD_W'(csy);
        n1_prod[3] = PROD_W'(c11) * PROD_W'(csx);
        n1_prod[4] = PROD_W'(c01) * PROD_W'(csx);
        n1_prod[5] = PROD_W'(c00) * PROD_W'(csy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    // stage 1 and 2 payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_coef <= i_coef;
            for (int k = 0; k < LANES; k++) begin
                r1_prod[k] <= n1_prod[k];
            end
            r2_coef <= r1_coef;
            r2_det  <= DIFF_W'(r1_prod[0]) - DIFF_W'(r1_prod[1]);
            r2_tx   <= DIFF_W'(r1_prod[2]) - DIFF_W'(r1_prod[3]);
            r2_ty   <= DIFF_W'(r1_prod[4]) - DIFF_W'(r1_prod[5]);
        end
    end

    // magnitudes, signs, singular test and first divider record
    logic                      det_neg, tx_neg, ty_neg;
    logic [DIFF_W-1:0]         det_mag, tx_mag, ty_mag;
    logic [COEF_WIDTH:0]       c_mag [LANES];
    logic [LANES-1:0]          c_neg;
    logic [RW-1:0]             num_mag [LANES];

    always_comb begin
        det_neg = r2_det[DIFF_W-1];
        tx_neg  = r2_tx[DIFF_W-1];
        ty_neg  = r2_ty[DIFF_W-1];
        det_mag = det_neg ? DIFF_W'(-r2_det) : DIFF_W'(r2_det);
        tx_mag  = tx_neg  ? DIFF_W'(-r2_tx)  : DIFF_W'(r2_tx);
        ty_mag  = ty_neg  ? DIFF_W'(-r2_ty)  : DIFF_W'(r2_ty);
        for (int k = 0; k < LANES; k++) begin
            c_neg[k] = r2_coef[k][COEF_WIDTH-1];
            c_mag[k] = c_neg[k] ? (COEF_WIDTH+1)'(-{1'b1, r2_coef[k]})
                                : {1'b0, r2_coef[k]};
        end
        num_mag[0] = RW'(c_mag[L_A11]) << (2 * FRAC_BITS);
        num_mag[1] = RW'(c_mag[L_A01]) << (2 * FRAC_BITS);
        num_mag[2] = RW'(c_mag[L_A10]) << (2 * FRAC_BITS);
        num_mag[3] = RW'(c_mag[L_A00]) << (2 * FRAC_BITS);
        num_mag[4] = RW'(tx_mag) << FRAC_BITS;
        num_mag[5] = RW'(ty_mag) << FRAC_BITS;

        n_div           = '0;
        n_div.tag.valid = r2_valid;
        n_div.tag.sing  = (r2_det == '0) || (det_mag < DIFF_W'(i_limit));
        n_div.tag.coef  = r2_coef;
        n_div.tag.neg[0] = c_neg[L_A11] ^ det_neg;
        n_div.tag.neg[1] = ~c_neg[L_A01] ^ det_neg;
        n_div.tag.neg[2] = ~c_neg[L_A10] ^ det_neg;
        n_div.tag.neg[3] = c_neg[L_A00] ^ det_neg;
        n_div.tag.neg[4] = tx_neg ^ det_neg;
        n_div.tag.neg[5] = ty_neg ^ det_neg;
        n_div.ds        = RW'(det_mag) << QBITS;
        for (int k = 0; k < LANES; k++) begin
            n_div.rem[k] = (num_mag[k] << 1) + RW'(det_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_div.tag.valid <= n_div.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div.tag.sing <= n_div.tag.sing;
            r_div.tag.neg  <= n_div.tag.neg;
            r_div.tag.coef <= n_div.tag.coef;
            r_div.ds       <= n_div.ds;
            r_div.rem      <= n_div.rem;
            r_div.quo      <= n_div.quo;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

### src/affinv_div_cell.sv
// one restoring division step for all six lanes, one quotient bit per cell
`default_nettype none

module affinv_div_cell
    import affinv_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  t_div  i_div,
    output t_div  o_div
);

    t_div r_div;
    t_div n_div;

    // compare against the shifted divisor, subtract on hit
    always_comb begin
        n_div     = i_div;
        n_div.ds  = i_div.ds >> 1;
        for (int k = 0; k < LANES; k++) begin
            if (i_div.rem[k] >= i_div.ds) begin
                n_div.rem[k] = i_div.rem[k] - i_div.ds;
                n_div.quo[k] = {i_div.quo[k][QBITS-2:0], 1'b1};
            end else begin
                n_div.quo[k] = {i_div.quo[k][QBITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_div.tag.valid <= n_div.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div.tag.sing <= n_div.tag.sing;
            r_div.tag.neg  <= n_div.tag.neg;
            r_div.tag.coef <= n_div.tag.coef;
            r_div.ds       <= n_div.ds;
            r_div.rem      <= n_div.rem;
            r_div.quo      <= n_div.quo;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

### src/affinv_out.sv
// sign, saturation, singular bypass and the output register
`default_nettype none

module affinv_out
    import affinv_pkg::*;
(
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  t_div                             i_div,
    output logic                             o_valid,
    output logic [LANES-1:0][COEF_WIDTH-1:0] o_data,
    output logic [USER_W-1:0]                o_user
);

    localparam logic [QBITS-1:0] QLIM = QBITS'(1) << (COEF_WIDTH - 1);
    localparam logic [COEF_WIDTH-1:0] POS_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] NEG_MAX = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic                             r_valid;
    logic [LANES-1:0][COEF_WIDTH-1:0] r_data;
    logic [USER_W-1:0]                r_user;
    logic [LANES-1:0][COEF_WIDTH-1:0] n_data;
    logic [USER_W-1:0]                n_user;
    logic [LANES-1:0]                 clip;

    // apply sign and clip each quotient
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (!i_div.tag.neg[k]) begin
                clip[k]   = (i_div.quo[k] >= QLIM);
                n_data[k] = clip[k] ? POS_MAX : i_div.quo[k][COEF_WIDTH-1:0];
            end else begin
                clip[k]   = (i_div.quo[k] > QLIM);
                n_data[k] = clip[k] ? NEG_MAX
                                    : COEF_WIDTH'(-i_div.quo[k][COEF_WIDTH-1:0]);
            end
        end
        if (i_div.tag.sing) begin
            n_data = i_div.tag.coef;
            n_user = 2'b01;
        end else begin
            n_user = {|clip, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_user <= n_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

endmodule

`default_nettype wire

### src/affine_2d_matrix_inverse_unit.sv
// top level of the 2d affine matrix inverse unit
`default_nettype none

// Inverts a 2d affine matrix (2x2 linear part plus translation row), Q16.16.
// Input requests arrive on the s_axis channel: tdata carries a00, a01, a10,
// a11, shift_x, shift_y from the low bits up, 32 bits each.
// Results leave on the m_axis channel: tdata carries inv00, inv01, inv10,
// inv11, inv_shift_x, inv_shift_y; tuser bit 0 is singular, bit 1 saturated.
// A singular matrix comes back unchanged with singular set.
// The limit register is written over the cfg channel, always ready; write it
// only while no request is in flight.
// From accept to result a request passes the product, determinant and setup
// registers, 34 divider cells (one quotient bit each, all six entries side by
// side) and the output register.
// One request is accepted every cycle while the output side takes results.
// When m_axis_tready is low and a result is held, the whole pipeline freezes
// and s_axis_tready drops; bubbles are not squeezed out.
// A synchronous active-low reset empties the pipeline and sets the limit to 1.
module affine_2d_matrix_inverse_unit
    import affinv_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // a00, a01, a10, a11, shift_x, shift_y
    input  wire [LANES*COEF_WIDTH-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // inv00, inv01, inv10, inv11, inv_shift_x, inv_shift_y
    output logic [LANES*COEF_WIDTH-1:0]   m_axis_tdata,
    // singular, saturated
    output logic [USER_W-1:0]             m_axis_tuser,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [LIMIT_W-1:0]             i_cfg_data
);

    logic                             w_en;
    logic                             w_out_valid;
    logic [LANES-1:0][COEF_WIDTH-1:0] w_out_data;
    logic [USER_W-1:0]                w_out_user;
    logic [LIMIT_W-1:0]               r_limit;
    t_div                             w_chain [QBITS+1];

    // pipeline advances unless a result is held and stalled
    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(1);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    affinv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_coef  (s_axis_tdata),
        .i_limit (r_limit),
        .o_div   (w_chain[0])
    );

    // row of divider cells
    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        affinv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_chain[g]),
            .o_div   (w_chain[g+1])
        );
    end

    affinv_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (w_chain[QBITS]),
        .o_valid (w_out_valid),
        .o_data  (w_out_data),
        .o_user  (w_out_user)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = w_out_data;
    assign m_axis_tuser  = w_out_user;

endmodule

`default_nettype wire

### dv/affine_2d_matrix_inverse_unit_tb.sv
// self-checking testbench for the 2d affine matrix inverse unit
`timescale 1ns / 100ps

module affine_2d_matrix_inverse_unit_tb;
    import affinv_pkg::*;

    typedef struct {
        logic [COEF_WIDTH-1:0] inv [LANES];
        logic                  singular;
        logic                  saturated;
    } t_inverse;

    // predicts inverses and holds them in order of arrival
    class inverse_scoreboard;
        logic [LIMIT_W-1:0] det_floor;
        t_inverse           pending[$];
        int                 errors;

        function new();
            det_floor = 1;
            errors    = 0;
        endfunction

        // rounded quotient, ties away from zero, clipped to the coefficient range
        function automatic logic [COEF_WIDTH-1:0] round_div(logic signed [130:0] num,
                logic signed [130:0] den, ref logic sat);
            logic [130:0] n_mag;
            logic [130:0] d_mag;
            logic [130:0] q;
            logic         neg;
            neg   = num[130] ^ den[130];
            n_mag = num[130] ? -num : num;
            d_mag = den[130] ? -den : den;
            q     = (2 * n_mag + d_mag) / (2 * d_mag);
            if (!neg) begin
                if (q > 131'(2147483647)) begin
                    sat = 1;
                    return 32'h7fff_ffff;
                end
                return q[31:0];
            end
            if (q > 131'(32'h8000_0000)) begin
                sat = 1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        endfunction

        function void note_request(logic [LANES*COEF_WIDTH-1:0] data);
            logic signed [130:0] c [LANES];
            logic signed [130:0] det;
            logic signed [130:0] mag;
            t_inverse            e;
            for (int k = 0; k < LANES; k++)
                c[k] = 131'($signed(data[k*COEF_WIDTH +: COEF_WIDTH]));
            det = c[L_A00] * c[L_A11] - c[L_A01] * c[L_A10];
            mag = det < 0 ? -det : det;
            e.saturated = 0;
            if (det == 0 || mag < 131'(det_floor)) begin
                for (int k = 0; k < LANES; k++) e.inv[k] = data[k*COEF_WIDTH +: COEF_WIDTH];
                e.singular = 1;
            end else begin
                e.singular = 0;
                e.inv[0] = round_div(c[L_A11] <<< 32, det, e.saturated);
                e.inv[1] = round_div(-(c[L_A01] <<< 32), det, e.saturated);
                e.inv[2] = round_div(-(c[L_A10] <<< 32), det, e.saturated);
                e.inv[3] = round_div(c[L_A00] <<< 32, det, e.saturated);
                e.inv[4] = round_div((c[L_A10] * c[L_SY] - c[L_A11] * c[L_SX]) <<< 16,
                                     det, e.saturated);
                e.inv[5] = round_div((c[L_A01] * c[L_SX] - c[L_A00] * c[L_SY]) <<< 16,
                                     det, e.saturated);
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [LANES*COEF_WIDTH-1:0] data,
                logic [USER_W-1:0] user);
            t_inverse e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < LANES; k++)
                if (data[k*COEF_WIDTH +: COEF_WIDTH] !== e.inv[k]) begin
                    $display("%0t: coef %0d expected %h actual %h", $time, k, e.inv[k],
                             data[k*COEF_WIDTH +: COEF_WIDTH]);
                    errors++;
                end
            if (user[0] !== e.singular) begin
                $display("%0t: singular expected %b actual %b", $time, e.singular, user[0]);
                errors++;
            end
            if (user[1] !== e.saturated) begin
                $display("%0t: saturated expected %b actual %b", $time, e.saturated, user[1]);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 38;
    localparam longint CYCLE_LIMIT = 400000;

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        s_axis_tvalid = 0;
    logic                        s_axis_tready;
    logic [LANES*COEF_WIDTH-1:0] s_axis_tdata = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 0;
    logic [LANES*COEF_WIDTH-1:0] m_axis_tdata;
    logic [USER_W-1:0]           m_axis_tuser;
    logic                        i_cfg_valid = 0;
    logic                        o_cfg_ready;
    logic [LIMIT_W-1:0]          i_cfg_data = '0;

    inverse_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    longint cycles = 0;

    affine_2d_matrix_inverse_unit u_dut (.*);

    always #2 i_clk = ~i_clk;

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // check results at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

    // receiver: random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.det_floor = v;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_request(logic [LANES*COEF_WIDTH-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(d);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(16'hffff)) - 32768);
            2: return {{14{1'($urandom_range(1))}}, 18'($urandom())};
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed(20'($urandom())) <<< $urandom_range(12));
        endcase
    endfunction

    // random matrix, sometimes nearly singular by making rows proportional
    function automatic logic [LANES*COEF_WIDTH-1:0] rand_matrix();
        logic [31:0] c [LANES];
        for (int k = 0; k < LANES; k++) c[k] = rand_coef();
        if ($urandom_range(7) == 0) begin
            c[L_A10] = c[L_A00];
            c[L_A11] = c[L_A01] + $urandom_range(2);
        end
        return {c[5], c[4], c[3], c[2], c[1], c[0]};
    endfunction

    function automatic logic [LANES*COEF_WIDTH-1:0] pack(logic [31:0] a00, logic [31:0] a01,
            logic [31:0] a10, logic [31:0] a11, logic [31:0] sx, logic [31:0] sy);
        return {sy, sx, a11, a10, a01, a00};
    endfunction

    initial begin
        logic [LIMIT_W-1:0] limits [5];
        limits = '{32'd0, 32'hffff_ffff, 32'h0001_0000, 32'd1, 32'd5000};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed corners at the reset limit
        send_request(pack(32'h1_0000, 0, 0, 32'h1_0000, 32'h2_0000, 32'hffff_0000));
        send_request('0);
        send_request(pack(1, 0, 0, 1, 5, 7));
        send_request(pack(32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_request(pack(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h8000_0000));
        send_request(pack(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
        send_request(pack(2, 4, 1, 2, 3, 3));
        send_request(pack(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          32'h0003_8000, 32'hfffe_0000));
        send_request(pack(32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 1));
        send_request(pack(3, 0, 0, 1, 1, 1));
        send_request(pack(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1));
        drain();

        // long receiver hold-off while the sender keeps going
        hold_off = 200;
        for (int i = 0; i < 80; i++) send_request(rand_matrix());
        drain();

        for (int ph = 0; ph < 20; ph++) begin
            write_limit(ph < 5 ? limits[ph] : $urandom());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int i = 0; i < 93; i++) send_request(rand_matrix());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

### files.f
src/affinv_pkg.sv
src/affinv_front.sv
src/affinv_div_cell.sv
src/affinv_out.sv
src/affine_2d_matrix_inverse_unit.sv
dv/affine_2d_matrix_inverse_unit_tb.sv
